// ===== src/uwl_pkg.sv =====
// Shared types and constants for the UTF-8 decoder with greedy line wrap.
// Used by the decode front end, the bundle queue, the layout back end and the top level.
package uwl_pkg;

	localparam int WIDTH_W    = 12;
	localparam int USED_W     = 13;
	localparam int LINE_W     = 16;
	localparam int CP_W       = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd240;
	localparam logic [WIDTH_W-1:0] MIN_WIDTH   = 12'd12;
	localparam logic [3:0]         NARROW_PX   = 4'd6;
	localparam logic [3:0]         WIDE_PX     = 4'd12;
	localparam logic [LINE_W-1:0]  LINE_MAX    = 16'hFFFF;

	localparam logic [CP_W-1:0] CP_BAD     = 16'h003F;
	localparam logic [CP_W-1:0] CP_NEWLINE = 16'h000A;
	localparam logic [CP_W-1:0] CP_SPACE   = 16'h0020;
	localparam logic [CP_W-1:0] CP_ASCII_LIMIT = 16'h0080;
	localparam logic [CP_W-1:0] CP_3BYTE_MIN   = 16'h0800;

	localparam logic [1:0] KIND_GLYPH   = 2'd0;
	localparam logic [1:0] KIND_NEWLINE = 2'd1;
	localparam logic [1:0] KIND_DROP    = 2'd2;
	localparam logic [1:0] KIND_END     = 2'd3;

	// One layout operation: a code point to place, or the end of the string.
	typedef struct packed {
		logic            is_end;
		logic [CP_W-1:0] cp;
	} op_t;

	// All operations caused by one input byte.
	typedef struct packed {
		op_t [2:0]  ops;
		logic [1:0] cnt;
		logic       seen;
	} bundle_t;

endpackage

// ===== src/utf8_decode_and_line_wrap.sv =====
// Top level of the UTF-8 decoder with greedy line wrap.
// Depends on uwl_pkg, uwl_front, uwl_queue and uwl_layout.
//
// Usage:
//   Input channel (in_valid / in_stall / text_byte) carries one text byte per item;
//   a zero byte ends the string, flushes pending bytes and yields the end summary.
//   Output channel (out_valid / out_stall / result fields) carries one result per
//   item; last marks the final result caused by an input byte. A byte that only
//   opens a multi-byte sequence causes no result.
//   cfg_we / cfg_wdata write wrap_width (reset 240); write only while idle.
// Timing:
//   The front end decodes a byte in the cycle it is accepted and queues a bundle of
//   up to three layout operations. The layout unit places one operation per cycle
//   unless a stalled result holds the output register. Each bundle is written into
//   the queue, and each of its 1 to 3 results is registered in the output register.
//   Unstalled plain text runs at one byte per cycle; the four-entry queue absorbs bursts.
// Reset: clears pending bytes, pixel count, line counter (to one) and the queue.
// Stall: a stalled result holds in the output register; the queue fills and then
//   in_stall rises until the receiver takes results again.
module utf8_decode_and_line_wrap (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] code_point,
	output logic [15:0] line_index,
	output logic [11:0] column_px,
	output logic [3:0]  glyph_px,
	output logic [15:0] total_lines,
	output logic        last
);
	import uwl_pkg::*;

	logic [WIDTH_W-1:0] wrap_width_q;
	logic               accept, push, pop, full, nonempty;
	bundle_t            push_bundle, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			wrap_width_q <= cfg_wdata;
		end
	end

	assign in_stall = full;
	assign accept   = in_valid && !full;

	uwl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_byte (text_byte),
		.push      (push),
		.bundle    (push_bundle)
	);

	uwl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (push_bundle),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.rdata    (head)
	);

	uwl_layout u_layout (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (nonempty),
		.head        (head),
		.pop         (pop),
		.wrap_width  (wrap_width_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.code_point  (code_point),
		.line_index  (line_index),
		.column_px   (column_px),
		.glyph_px    (glyph_px),
		.total_lines (total_lines),
		.last        (last)
	);

endmodule

// ===== src/uwl_front.sv =====
// Decode front end: accepts text bytes, tracks pending UTF-8 lead and continuation
// bytes and emits a bundle of layout operations per byte. Depends on uwl_pkg.
module uwl_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     text_byte,
	output logic           push,
	output uwl_pkg::bundle_t bundle
);
	import uwl_pkg::*;

	logic [1:0] pend_cnt_q, pend_cnt_n;
	logic [7:0] pend0_q, pend0_n;
	logic [7:0] pend1_q, pend1_n;
	logic       seen_q, seen_n;

	function automatic bundle_t push_op(bundle_t bd, logic is_end, logic [CP_W-1:0] cp);
		bd.ops[bd.cnt] = '{is_end: is_end, cp: cp};
		bd.cnt = bd.cnt + 2'd1;
		return bd;
	endfunction

	logic            b_cont, b_ascii, b_lead;
	logic [CP_W-1:0] cp2, cp3;

	always_comb begin
		b_cont  = (text_byte[7:6] == 2'b10);
		b_ascii = !text_byte[7];
		b_lead  = (text_byte[7:5] == 3'b110) || (text_byte[7:4] == 4'b1110);
		cp2 = {5'd0, pend0_q[4:0], text_byte[5:0]};
		cp3 = {pend0_q[3:0], pend1_q[5:0], text_byte[5:0]};

		bundle     = '0;
		pend_cnt_n = pend_cnt_q;
		pend0_n    = pend0_q;
		pend1_n    = pend1_q;
		seen_n     = seen_q;

		if (text_byte == 8'd0) begin
			// flush pending bytes as one bad glyph each, then end the string
			if (pend_cnt_q != 2'd0) bundle = push_op(bundle, 1'b0, CP_BAD);
			if (pend_cnt_q == 2'd2) bundle = push_op(bundle, 1'b0, CP_BAD);
			bundle.seen = seen_q;
			bundle = push_op(bundle, 1'b1, '0);
			pend_cnt_n = 2'd0;
			seen_n = 1'b0;
		end else begin
			seen_n = 1'b1;
			pend_cnt_n = 2'd0;
			case (pend_cnt_q)
				2'd1: begin
					if (b_cont && pend0_q[7:5] == 3'b110) begin
						bundle = push_op(bundle, 1'b0, (cp2 >= CP_ASCII_LIMIT) ? cp2 : CP_BAD);
					end else if (b_cont) begin
						pend1_n = text_byte;
						pend_cnt_n = 2'd2;
					end else begin
						bundle = push_op(bundle, 1'b0, CP_BAD);
					end
				end
				2'd2: begin
					if (b_cont) begin
						bundle = push_op(bundle, 1'b0, (cp3 >= CP_3BYTE_MIN) ? cp3 : CP_BAD);
					end else begin
						bundle = push_op(bundle, 1'b0, CP_BAD);
						bundle = push_op(bundle, 1'b0, CP_BAD);
					end
				end
				default: ;
			endcase
			// decode this byte from the start unless it was taken as a continuation
			if (pend_cnt_q == 2'd0 || !b_cont) begin
				if (b_ascii) begin
					bundle = push_op(bundle, 1'b0, {8'd0, text_byte});
				end else if (b_lead) begin
					pend0_n = text_byte;
					pend_cnt_n = 2'd1;
				end else begin
					bundle = push_op(bundle, 1'b0, CP_BAD);
				end
			end
		end
	end

	assign push = accept && (bundle.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= 2'd0;
			seen_q <= 1'b0;
		end else if (accept) begin
			pend_cnt_q <= pend_cnt_n;
			seen_q <= seen_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend0_q <= pend0_n;
			pend1_q <= pend1_n;
		end
	end

endmodule

// ===== src/uwl_queue.sv =====
// Short bundle queue between the decode front end and the layout back end.
// Depends on uwl_pkg.
module uwl_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  uwl_pkg::bundle_t wdata,
	input  logic             pop,
	output logic             full,
	output logic             nonempty,
	output uwl_pkg::bundle_t rdata
);
	import uwl_pkg::*;

	bundle_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wptr_q, rptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== src/uwl_layout.sv =====
// Layout back end: places one operation per cycle with greedy wrap unless a stalled
// result blocks it, and drives the registered result channel. Depends on uwl_pkg.
module uwl_layout (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  uwl_pkg::bundle_t            head,
	output logic                        pop,
	input  logic [uwl_pkg::WIDTH_W-1:0] wrap_width,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  kind,
	output logic [15:0]                 code_point,
	output logic [15:0]                 line_index,
	output logic [11:0]                 column_px,
	output logic [3:0]                  glyph_px,
	output logic [15:0]                 total_lines,
	output logic                        last
);
	import uwl_pkg::*;

	logic [1:0]        idx_q;
	logic [USED_W-1:0] used_q, used_n;
	logic [LINE_W-1:0] line_q, line_n;
	logic              out_valid_q;
	logic [1:0]        kind_q, kind_n;
	logic [CP_W-1:0]   cp_q, cp_n;
	logic [LINE_W-1:0] line_idx_q, line_idx_n;
	logic [11:0]       col_q, col_n;
	logic [3:0]        gpx_q, gpx_n;
	logic [LINE_W-1:0] total_q, total_n;
	logic              last_q, last_n;

	op_t               op;
	logic              fire;
	logic [3:0]        gw;
	logic              fits;
	logic [LINE_W-1:0] line_inc, line_use;
	logic [USED_W-1:0] used_use;

	always_comb begin
		op       = head.ops[idx_q];
		fire     = head_valid && (!out_valid_q || !out_stall);
		last_n   = (idx_q == head.cnt - 2'd1);
		pop      = fire && last_n;
		gw       = (op.cp < CP_ASCII_LIMIT) ? NARROW_PX : WIDE_PX;
		fits     = ({1'b0, used_q} + 14'(gw)) <= 14'(wrap_width);
		line_inc = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
		line_use = fits ? line_q : line_inc;
		used_use = fits ? used_q : '0;

		kind_n     = KIND_GLYPH;
		cp_n       = op.cp;
		line_idx_n = line_use - 1'b1;
		col_n      = used_use[11:0];
		gpx_n      = gw;
		total_n    = '0;
		used_n     = used_use + USED_W'(gw);
		line_n     = line_use;

		if (op.is_end) begin
			kind_n     = KIND_END;
			cp_n       = '0;
			line_idx_n = '0;
			col_n      = '0;
			gpx_n      = '0;
			total_n    = (wrap_width < MIN_WIDTH || !head.seen) ? '0 : line_q;
			used_n     = '0;
			line_n     = LINE_W'(1);
		end else if (op.cp == CP_NEWLINE) begin
			kind_n     = KIND_NEWLINE;
			line_idx_n = line_q - 1'b1;
			col_n      = used_q[11:0];
			gpx_n      = '0;
			used_n     = '0;
			line_n     = line_inc;
		end else if (!fits && op.cp == CP_SPACE) begin
			// drop the space that caused the wrap
			kind_n = KIND_DROP;
			col_n  = '0;
			gpx_n  = NARROW_PX;
			used_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			used_q <= '0;
			line_q <= LINE_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				idx_q <= last_n ? 2'd0 : idx_q + 2'd1;
				used_q <= used_n;
				line_q <= line_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q <= kind_n;
			cp_q <= cp_n;
			line_idx_q <= line_idx_n;
			col_q <= col_n;
			gpx_q <= gpx_n;
			total_q <= total_n;
			last_q <= last_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign code_point  = cp_q;
	assign line_index  = line_idx_q;
	assign column_px   = col_q;
	assign glyph_px    = gpx_q;
	assign total_lines = total_q;
	assign last        = last_q;

endmodule
